// ----- src/tun_pkg.sv -----
// Package for the triangle unit normal block: widths, item types and reset constants.
// Used by every file of the block; depends on nothing.
package tun_pkg;

  localparam int CoordW   = 24;
  localparam int EdgeW    = 25;
  localparam int ProdW    = 50;
  localparam int CrossW   = 51;
  localparam int MagW     = 50;
  localparam int NormBits = 30;
  localparam int RootW    = 31;
  localparam int QuotW    = 31;
  localparam int OutW     = 32;
  localparam int CfgW     = 32;
  localparam int ThrW     = 64;

  localparam logic [CfgW-1:0] MinLenReset = 32'd429497;
  localparam logic [ThrW-1:0] ThrReset    = 64'(MinLenReset) * 64'(MinLenReset);

  typedef struct packed {
    logic signed [CoordW-1:0] a_x;
    logic signed [CoordW-1:0] a_y;
    logic signed [CoordW-1:0] a_z;
    logic signed [CoordW-1:0] b_x;
    logic signed [CoordW-1:0] b_y;
    logic signed [CoordW-1:0] b_z;
    logic signed [CoordW-1:0] c_x;
    logic signed [CoordW-1:0] c_y;
    logic signed [CoordW-1:0] c_z;
  } in_item_t;

  typedef struct packed {
    logic [2:0][MagW-1:0] mag;
    logic [2:0]           neg;
    logic                 degen;
  } mid_item_t;

  typedef struct packed {
    logic [2:0] neg;
    logic       degen;
  } side_t;

  typedef struct packed {
    logic signed [OutW-1:0] normal_x;
    logic signed [OutW-1:0] normal_y;
    logic signed [OutW-1:0] normal_z;
    logic                   degenerate;
  } out_item_t;

endpackage

// ----- src/tun_ifs.sv -----
// Channel interfaces of the triangle unit normal block: input, result and configuration.
// Depends on tun_pkg for the field widths.
interface tun_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [tun_pkg::CoordW-1:0] a_x;
  logic signed [tun_pkg::CoordW-1:0] a_y;
  logic signed [tun_pkg::CoordW-1:0] a_z;
  logic signed [tun_pkg::CoordW-1:0] b_x;
  logic signed [tun_pkg::CoordW-1:0] b_y;
  logic signed [tun_pkg::CoordW-1:0] b_z;
  logic signed [tun_pkg::CoordW-1:0] c_x;
  logic signed [tun_pkg::CoordW-1:0] c_y;
  logic signed [tun_pkg::CoordW-1:0] c_z;
  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, input ready);
  modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, output ready);
endinterface

interface tun_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [tun_pkg::OutW-1:0] normal_x;
  logic signed [tun_pkg::OutW-1:0] normal_y;
  logic signed [tun_pkg::OutW-1:0] normal_z;
  logic                            degenerate;
  modport source (output valid, normal_x, normal_y, normal_z, degenerate, input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface

interface tun_cfg_if;
  logic                     valid;
  logic                     ready;
  logic [tun_pkg::CfgW-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ----- src/tun_front.sv -----
// Front pipeline: edge vectors, exact cross product, magnitudes and the degenerate test.
// Depends on tun_pkg; feeds the queue in tun_fifo.
module tun_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  tun_pkg::in_item_t          in_item,
  input  logic [tun_pkg::ThrW-1:0]   thr,
  output logic                       push_valid,
  input  logic                       push_ready,
  output tun_pkg::mid_item_t         push_item
);

  logic                               en;
  logic [4:0]                         v_r;
  logic signed [tun_pkg::EdgeW-1:0]   e1_r [3];
  logic signed [tun_pkg::EdgeW-1:0]   e2_r [3];
  logic signed [tun_pkg::ProdW-1:0]   p_r [6];
  logic [tun_pkg::CrossW-1:0]         cr [3];
  logic [tun_pkg::CrossW-1:0]         abs_nxt [3];
  logic [2:0][tun_pkg::MagW-1:0]      mag2_r;
  logic [2:0]                         neg2_r;
  logic [2:0][tun_pkg::MagW-1:0]      mag3_r;
  logic [2:0]                         neg3_r;
  logic                               hi3_r;
  logic                               zero3_r;
  logic [63:0]                        sq3_r [3];
  logic [65:0]                        sum_nxt;
  tun_pkg::mid_item_t                 item_r;

  assign en         = !v_r[4] || push_ready;
  assign in_ready   = en;
  assign push_valid = v_r[4];
  assign push_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[3:0], in_valid};
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cr[i]      = {p_r[2*i][tun_pkg::ProdW-1], p_r[2*i]}
                 - {p_r[2*i+1][tun_pkg::ProdW-1], p_r[2*i+1]};
      abs_nxt[i] = cr[i][tun_pkg::CrossW-1] ? (~cr[i] + 1'b1) : cr[i];
    end
    sum_nxt = 66'(sq3_r[0]) + 66'(sq3_r[1]) + 66'(sq3_r[2]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1_r[0] <= {in_item.b_x[23], in_item.b_x} - {in_item.a_x[23], in_item.a_x};
      e1_r[1] <= {in_item.b_y[23], in_item.b_y} - {in_item.a_y[23], in_item.a_y};
      e1_r[2] <= {in_item.b_z[23], in_item.b_z} - {in_item.a_z[23], in_item.a_z};
      e2_r[0] <= {in_item.c_x[23], in_item.c_x} - {in_item.a_x[23], in_item.a_x};
      e2_r[1] <= {in_item.c_y[23], in_item.c_y} - {in_item.a_y[23], in_item.a_y};
      e2_r[2] <= {in_item.c_z[23], in_item.c_z} - {in_item.a_z[23], in_item.a_z};

      p_r[0] <= e1_r[1] * e2_r[2];
      p_r[1] <= e1_r[2] * e2_r[1];
      p_r[2] <= e1_r[2] * e2_r[0];
      p_r[3] <= e1_r[0] * e2_r[2];
      p_r[4] <= e1_r[0] * e2_r[1];
      p_r[5] <= e1_r[1] * e2_r[0];

      for (int i = 0; i < 3; i++) begin
        mag2_r[i] <= abs_nxt[i][tun_pkg::MagW-1:0];
        neg2_r[i] <= cr[i][tun_pkg::CrossW-1];
        sq3_r[i]  <= mag2_r[i][31:0] * mag2_r[i][31:0];
      end

      mag3_r  <= mag2_r;
      neg3_r  <= neg2_r;
      hi3_r   <= |{mag2_r[0][49:32], mag2_r[1][49:32], mag2_r[2][49:32]};
      zero3_r <= (mag2_r == '0);

      item_r.mag   <= mag3_r;
      item_r.neg   <= neg3_r;
      item_r.degen <= zero3_r || (!hi3_r && (sum_nxt < {2'b00, thr}));
    end
  end

endmodule

// ----- src/tun_fifo.sv -----
// Short queue that decouples the front pipeline from the back pipeline.
// Depends on tun_pkg for the item type.
module tun_fifo #(
  parameter int Depth = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  tun_pkg::mid_item_t push_item,
  output logic               pop_valid,
  input  logic               pop_ready,
  output tun_pkg::mid_item_t pop_item
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  tun_pkg::mid_item_t mem_r [Depth];
  logic [AW-1:0]      wr_ptr_r;
  logic [AW-1:0]      rd_ptr_r;
  logic [CW-1:0]      count_r;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (count_r != CW'(Depth));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ----- src/tun_back.sv -----
// Back pipeline: normalizing shift, pipelined square root, three pipelined dividers, output.
// Depends on tun_pkg; takes items from tun_fifo.
module tun_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  tun_pkg::mid_item_t pop_item,
  output logic               out_valid,
  input  logic               out_ready,
  output tun_pkg::out_item_t out_item
);

  localparam int SqSt  = tun_pkg::RootW;
  localparam int DivSt = tun_pkg::QuotW;
  localparam int NB    = tun_pkg::NormBits;

  function automatic logic [3:0] bitlen10(input logic [9:0] v);
    logic [3:0] n;
    n = '0;
    for (int j = 0; j < 10; j++) begin
      if (v[j]) n = 4'(j + 1);
    end
    return n;
  endfunction

  logic                          en;
  logic [3:0]                    pre_v_r;
  logic [SqSt:0]                 sq_v_r;
  logic [DivSt:0]                dv_v_r;
  logic                          out_v_r;

  logic [tun_pkg::MagW-1:0]      or_all;
  logic [2:0][tun_pkg::MagW-1:0] b0_mag_r;
  tun_pkg::side_t                b0_side_r;
  logic [4:0]                    grp_nz_r;
  logic [3:0]                    grp_len_r [5];

  logic [5:0]                    e_nxt;
  logic [5:0]                    e_r;
  logic [2:0][tun_pkg::MagW-1:0] b1_mag_r;
  tun_pkg::side_t                b1_side_r;

  logic [2:0][NB-1:0]            m_nxt;
  logic [tun_pkg::MagW-1:0]      rsh [3];
  logic [2:0][NB-1:0]            b2_m_r;
  tun_pkg::side_t                b2_side_r;

  logic [2*NB-1:0]               b3_sq_r [3];
  logic [2:0][NB-1:0]            b3_m_r;
  tun_pkg::side_t                b3_side_r;

  logic [2*NB+1:0]               sq_sum_r [SqSt+1];
  logic [2*NB+1:0]               sq_sum_nxt [SqSt+1];
  logic [32:0]                   sq_rem_r [SqSt+1];
  logic [32:0]                   sq_rem_nxt [SqSt+1];
  logic [tun_pkg::RootW-1:0]     sq_root_r [SqSt+1];
  logic [tun_pkg::RootW-1:0]     sq_root_nxt [SqSt+1];
  logic [2:0][NB-1:0]            sq_m_r [SqSt+1];
  tun_pkg::side_t                sq_side_r [SqSt+1];
  logic [34:0]                   rem_sh [SqSt];
  logic [34:0]                   trial [SqSt];

  logic [tun_pkg::RootW-1:0]     len;
  logic [2*NB:0]                 num [3];
  logic [2:0][30:0]              dv_rem_r [DivSt+1];
  logic [2:0][30:0]              dv_rem_nxt [DivSt+1];
  logic [2:0][30:0]              dv_low_r [DivSt+1];
  logic [2:0][30:0]              dv_low_nxt [DivSt+1];
  logic [2:0][tun_pkg::QuotW-1:0] dv_q_r [DivSt+1];
  logic [2:0][tun_pkg::QuotW-1:0] dv_q_nxt [DivSt+1];
  logic [tun_pkg::RootW-1:0]     dv_len_r [DivSt+1];
  tun_pkg::side_t                dv_side_r [DivSt+1];
  logic [31:0]                   r_sh [DivSt][3];

  logic [tun_pkg::OutW-1:0]      res_nxt [3];
  tun_pkg::out_item_t            out_r;

  assign en        = !out_v_r || out_ready;
  assign pop_ready = en;
  assign out_valid = out_v_r;
  assign out_item  = out_r;
  assign len       = sq_root_r[SqSt];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_v_r <= '0;
      sq_v_r  <= '0;
      dv_v_r  <= '0;
      out_v_r <= 1'b0;
    end else if (en) begin
      pre_v_r <= {pre_v_r[2:0], pop_valid};
      sq_v_r  <= {sq_v_r[SqSt-1:0], pre_v_r[3]};
      dv_v_r  <= {dv_v_r[DivSt-1:0], sq_v_r[SqSt]};
      out_v_r <= dv_v_r[DivSt];
    end
  end

  always_comb begin
    or_all = pop_item.mag[0] | pop_item.mag[1] | pop_item.mag[2];

    e_nxt = '0;
    for (int g = 0; g < 5; g++) begin
      if (grp_nz_r[g]) e_nxt = 6'(g * 10) + 6'(grp_len_r[g]);
    end

    for (int i = 0; i < 3; i++) begin
      rsh[i] = b1_mag_r[i] >> (e_r - 6'(NB));
      if (e_r > 6'(NB)) begin
        m_nxt[i] = rsh[i][NB-1:0];
      end else begin
        m_nxt[i] = b1_mag_r[i][NB-1:0] << (6'(NB) - e_r);
      end
    end

    for (int k = 0; k < SqSt; k++) begin
      rem_sh[k] = {sq_rem_r[k], sq_sum_r[k][2*NB+1:2*NB]};
      trial[k]  = 35'({sq_root_r[k], 2'b01});
      sq_sum_nxt[k] = {sq_sum_r[k][2*NB-1:0], 2'b00};
      if (rem_sh[k] >= trial[k]) begin
        sq_rem_nxt[k]  = 33'(rem_sh[k] - trial[k]);
        sq_root_nxt[k] = {sq_root_r[k][tun_pkg::RootW-2:0], 1'b1};
      end else begin
        sq_rem_nxt[k]  = rem_sh[k][32:0];
        sq_root_nxt[k] = {sq_root_r[k][tun_pkg::RootW-2:0], 1'b0};
      end
    end
    sq_sum_nxt[SqSt]  = '0;
    sq_rem_nxt[SqSt]  = '0;
    sq_root_nxt[SqSt] = '0;

    for (int i = 0; i < 3; i++) begin
      num[i] = {1'b0, sq_m_r[SqSt][i], {NB{1'b0}}} + (2*NB+1)'(len[tun_pkg::RootW-1:1]);
    end

    for (int j = 0; j < DivSt; j++) begin
      for (int i = 0; i < 3; i++) begin
        r_sh[j][i] = {dv_rem_r[j][i], dv_low_r[j][i][30]};
        dv_low_nxt[j][i] = {dv_low_r[j][i][29:0], 1'b0};
        if (r_sh[j][i] >= {1'b0, dv_len_r[j]}) begin
          dv_rem_nxt[j][i] = 31'(r_sh[j][i] - {1'b0, dv_len_r[j]});
          dv_q_nxt[j][i]   = {dv_q_r[j][i][tun_pkg::QuotW-2:0], 1'b1};
        end else begin
          dv_rem_nxt[j][i] = r_sh[j][i][30:0];
          dv_q_nxt[j][i]   = {dv_q_r[j][i][tun_pkg::QuotW-2:0], 1'b0};
        end
      end
    end
    dv_low_nxt[DivSt] = '0;
    dv_rem_nxt[DivSt] = '0;
    dv_q_nxt[DivSt]   = '0;

    for (int i = 0; i < 3; i++) begin
      if (dv_side_r[DivSt].degen) begin
        res_nxt[i] = '0;
      end else if (dv_side_r[DivSt].neg[i]) begin
        res_nxt[i] = '0 - {1'b0, dv_q_r[DivSt][i]};
      end else begin
        res_nxt[i] = {1'b0, dv_q_r[DivSt][i]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b0_mag_r        <= pop_item.mag;
      b0_side_r.neg   <= pop_item.neg;
      b0_side_r.degen <= pop_item.degen;
      for (int g = 0; g < 5; g++) begin
        grp_nz_r[g]  <= |or_all[g*10 +: 10];
        grp_len_r[g] <= bitlen10(or_all[g*10 +: 10]);
      end

      e_r       <= e_nxt;
      b1_mag_r  <= b0_mag_r;
      b1_side_r <= b0_side_r;

      b2_m_r    <= m_nxt;
      b2_side_r <= b1_side_r;

      for (int i = 0; i < 3; i++) begin
        b3_sq_r[i] <= b2_m_r[i] * b2_m_r[i];
      end
      b3_m_r    <= b2_m_r;
      b3_side_r <= b2_side_r;

      sq_sum_r[0]  <= (2*NB+2)'(b3_sq_r[0]) + (2*NB+2)'(b3_sq_r[1]) + (2*NB+2)'(b3_sq_r[2]);
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
      sq_m_r[0]    <= b3_m_r;
      sq_side_r[0] <= b3_side_r;
      for (int k = 0; k < SqSt; k++) begin
        sq_sum_r[k+1]  <= sq_sum_nxt[k];
        sq_rem_r[k+1]  <= sq_rem_nxt[k];
        sq_root_r[k+1] <= sq_root_nxt[k];
        sq_m_r[k+1]    <= sq_m_r[k];
        sq_side_r[k+1] <= sq_side_r[k];
      end

      for (int i = 0; i < 3; i++) begin
        dv_rem_r[0][i] <= {1'b0, num[i][2*NB:31]};
        dv_low_r[0][i] <= num[i][30:0];
        dv_q_r[0][i]   <= '0;
      end
      dv_len_r[0]  <= len;
      dv_side_r[0] <= sq_side_r[SqSt];
      for (int j = 0; j < DivSt; j++) begin
        dv_rem_r[j+1]  <= dv_rem_nxt[j];
        dv_low_r[j+1]  <= dv_low_nxt[j];
        dv_q_r[j+1]    <= dv_q_nxt[j];
        dv_len_r[j+1]  <= dv_len_r[j];
        dv_side_r[j+1] <= dv_side_r[j];
      end

      out_r.normal_x   <= res_nxt[0];
      out_r.normal_y   <= res_nxt[1];
      out_r.normal_z   <= res_nxt[2];
      out_r.degenerate <= dv_side_r[DivSt].degen;
    end
  end

endmodule

// ----- src/triangle_unit_normal.sv -----
// Throughput: one item per cycle while out_ch.ready does not stall the output; every
// stage is pipelined, and the square root and the three dividers take one bit per stage
// over 31 stages each.
// Reset: synchronous active-low rst_n empties all pipelines and the queue and sets the
// threshold back to its default. No clearing pass is needed.
module triangle_unit_normal #(
  parameter int QueueDepth = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  tun_in_if.sink     in_ch,
  tun_out_if.source  out_ch,
  tun_cfg_if.sink    cfg_ch
);

  logic [tun_pkg::ThrW-1:0] thr_r;
  tun_pkg::in_item_t        in_item;
  tun_pkg::mid_item_t       push_item;
  tun_pkg::mid_item_t       pop_item;
  tun_pkg::out_item_t       out_item;
  logic                     push_valid;
  logic                     push_ready;
  logic                     pop_valid;
  logic                     pop_ready;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= tun_pkg::ThrReset;
    end else if (cfg_ch.valid) begin
      thr_r <= 64'(cfg_ch.data) * 64'(cfg_ch.data);
    end
  end

  assign in_item.a_x = in_ch.a_x;
  assign in_item.a_y = in_ch.a_y;
  assign in_item.a_z = in_ch.a_z;
  assign in_item.b_x = in_ch.b_x;
  assign in_item.b_y = in_ch.b_y;
  assign in_item.b_z = in_ch.b_z;
  assign in_item.c_x = in_ch.c_x;
  assign in_item.c_y = in_ch.c_y;
  assign in_item.c_z = in_ch.c_z;

  tun_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_item    (in_item),
    .thr        (thr_r),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  tun_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  tun_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_item  (out_item)
  );

  assign out_ch.normal_x   = out_item.normal_x;
  assign out_ch.normal_y   = out_item.normal_y;
  assign out_ch.normal_z   = out_item.normal_z;
  assign out_ch.degenerate = out_item.degenerate;

endmodule

// ----- src/tun_checker.sv -----
// Port-level checks of the triangle unit normal block, bound to the top level.
// Depends on triangle_unit_normal and the channel interfaces.
module tun_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [31:0] normal_x,
  input logic signed [31:0] normal_y,
  input logic signed [31:0] normal_z,
  input logic              degenerate
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result shown right after reset.");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && degenerate |-> normal_x == 0 && normal_y == 0 && normal_z == 0)
    else $error("Degenerate item with a nonzero normal.");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !degenerate |->
      normal_x <= 32'sd1073741824 && normal_x >= -32'sd1073741824 &&
      normal_y <= 32'sd1073741824 && normal_y >= -32'sd1073741824 &&
      normal_z <= 32'sd1073741824 && normal_z >= -32'sd1073741824 &&
      (normal_x != 0 || normal_y != 0 || normal_z != 0))
    else $error("Normal component out of the unit range.");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(normal_x) && $stable(normal_y) &&
      $stable(normal_z) && $stable(degenerate))
    else $error("Stalled item changed.");

endmodule

bind triangle_unit_normal tun_checker u_tun_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .normal_x   (out_ch.normal_x),
  .normal_y   (out_ch.normal_y),
  .normal_z   (out_ch.normal_z),
  .degenerate (out_ch.degenerate)
);

// ----- test/tb_tun_ifs_note.sv -----
// Shared testbench types for the triangle unit normal bench.
// Depends on tun_pkg for field widths.
`timescale 1ns / 100ps
package tb_tun_types;

  typedef struct {
    logic signed [tun_pkg::OutW-1:0] nx;
    logic signed [tun_pkg::OutW-1:0] ny;
    logic signed [tun_pkg::OutW-1:0] nz;
    logic                            degen;
  } normal_t;
endpackage

// ----- test/tb_triangle_unit_normal.sv -----
// Testbench for triangle_unit_normal: drives triangles and threshold writes through the
// channel interfaces and checks each normal against an in-bench fixed-point predictor.
// Depends on tun_pkg, tun_ifs and tb_tun_types.
`timescale 1ns / 100ps
module tb_triangle_unit_normal;

  localparam int Latency = 74;
  localparam int WatchLimit = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  tun_in_if  in_ch();
  tun_out_if out_ch();
  tun_cfg_if cfg_ch();

  triangle_unit_normal DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source), .cfg_ch(cfg_ch.sink)
  );

  tb_tun_types::normal_t expected_normals[$];
  logic [tun_pkg::CfgW-1:0] threshold = tun_pkg::MinLenReset;
  int fails = 0;
  int idle_pct = 9;
  bit hold_sink = 1'b0;
  int quiet_cycles = 0;

  function automatic logic [63:0] root64(logic [63:0] n);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic tb_tun_types::normal_t face_normal(tun_pkg::in_item_t t,
                                                        logic [tun_pkg::CfgW-1:0] min_len);
    tb_tun_types::normal_t r;
    logic signed [63:0] e1 [3], e2 [3], cr [3];
    logic [63:0] mag [3], big, sum, len, q, v;
    logic [127:0] sq, thr;
    logic neg [3];
    int e;
    e1[0] = 64'(t.b_x) - 64'(t.a_x); e1[1] = 64'(t.b_y) - 64'(t.a_y);
    e1[2] = 64'(t.b_z) - 64'(t.a_z);
    e2[0] = 64'(t.c_x) - 64'(t.a_x); e2[1] = 64'(t.c_y) - 64'(t.a_y);
    e2[2] = 64'(t.c_z) - 64'(t.a_z);
    cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
    cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
    cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
    big = 0;
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = cr[i] < 0;
      mag[i] = neg[i] ? 64'(-cr[i]) : 64'(cr[i]);
      sq = sq + 128'(mag[i]) * 128'(mag[i]);
      if (mag[i] > big) big = mag[i];
    end
    thr = 128'(min_len) * 128'(min_len);
    r = '{0, 0, 0, 1'b1};
    if (big == 0 || sq < thr) return r;
    e = 0;
    for (int i = 0; i < 64; i++) if (big[i]) e = i + 1;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      if (e > tun_pkg::NormBits) mag[i] = mag[i] >> (e - tun_pkg::NormBits);
      else mag[i] = mag[i] << (tun_pkg::NormBits - e);
      sum = sum + mag[i] * mag[i];
    end
    len = root64(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << tun_pkg::NormBits) + (len >> 1)) / len;
      v = neg[i] ? -q : q;
      if (i == 0) r.nx = v[31:0];
      else if (i == 1) r.ny = v[31:0];
      else r.nz = v[31:0];
    end
    r.degen = 1'b0;
    return r;
  endfunction

  task automatic send_triangle(tun_pkg::in_item_t t);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    {in_ch.a_x, in_ch.a_y, in_ch.a_z, in_ch.b_x, in_ch.b_y, in_ch.b_z,
     in_ch.c_x, in_ch.c_y, in_ch.c_z} <= t;
    do @(posedge clk); while (!in_ch.ready);
    expected_normals.insert(expected_normals.size(), face_normal(t, threshold));
  endtask

  task automatic drain_pipe();
    in_ch.valid <= 1'b0;
    while (expected_normals.size() != 0) @(posedge clk);
    repeat (Latency + 10) @(posedge clk);
  endtask

  task automatic write_threshold(logic [tun_pkg::CfgW-1:0] val);
    drain_pipe();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    threshold = val;
  endtask

  function automatic tun_pkg::in_item_t random_raw();
    logic [7*32-1:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return raw[$bits(tun_pkg::in_item_t)-1:0];
  endfunction

  function automatic tun_pkg::in_item_t random_triangle();
    tun_pkg::in_item_t t;
    logic [tun_pkg::CoordW-1:0] base;
    int sh;
    t = random_raw();
    case ($urandom_range(5))
      0: begin
        sh = $urandom_range(23);
        t.b_x = t.a_x + ($signed(t.b_x) >>> sh); t.b_y = t.a_y + ($signed(t.b_y) >>> sh);
        t.b_z = t.a_z + ($signed(t.b_z) >>> sh); t.c_x = t.a_x + ($signed(t.c_x) >>> sh);
        t.c_y = t.a_y + ($signed(t.c_y) >>> sh); t.c_z = t.a_z + ($signed(t.c_z) >>> sh);
      end
      1: begin
        base = $urandom_range(3);
        t.c_x = t.a_x + base * (t.b_x - t.a_x); t.c_y = t.a_y + base * (t.b_y - t.a_y);
        t.c_z = t.a_z + base * (t.b_z - t.a_z);
      end
      2: begin
        t.c_x = t.a_x + $signed(4'($urandom)); t.c_y = t.a_y + $signed(4'($urandom));
        t.c_z = t.a_z; t.b_z = t.a_z + $signed(3'($urandom));
        t.b_x = t.a_x + $signed(3'($urandom)); t.b_y = t.a_y + $signed(3'($urandom));
      end
      default: ;
    endcase
    return t;
  endfunction

  task automatic test_directed();
    tun_pkg::in_item_t t;
    t = '0;
    send_triangle(t);
    t.b_x = 24'h7fffff; t.c_y = 24'h7fffff; t.a_x = 24'h800000; t.a_y = 24'h800000;
    t.a_z = 24'h800000;
    send_triangle(t);
    t = '0; t.b_x = 24'sd1; t.c_y = 24'sd1;
    send_triangle(t);
    t = '0; t.b_x = 24'h800000; t.c_y = 24'h7fffff; t.c_z = 24'h800000;
    send_triangle(t);
    t = '0; t.b_x = 24'd65536; t.c_z = 24'd65536;
    send_triangle(t);
    t = '0; t.b_x = 24'd5; t.c_x = 24'd10;
    send_triangle(t);
    t = {9{24'h800000}};
    send_triangle(t);
    t = {9{24'h7fffff}};
    send_triangle(t);
    for (int i = 0; i < 8; i++) begin
      t = '0; t.b_x = 24'd1 << (2 * i); t.c_y = 24'd1 << (2 * i);
      send_triangle(t);
    end
    for (int i = 0; i < 6; i++) send_triangle(random_raw());
  endtask

  task automatic test_thresholds();
    logic [tun_pkg::CfgW-1:0] vals [5];
    vals = '{32'd0, 32'hffffffff, 32'd1, 32'h00010000, tun_pkg::MinLenReset};
    foreach (vals[k]) begin
      write_threshold(vals[k]);
      for (int i = 0; i < 40; i++) send_triangle(random_triangle());
    end
  endtask

  task automatic test_backpressure();
    drain_pipe();
    idle_pct = 0;
    hold_sink = 1'b1;
    fork
      begin
        repeat (150) @(posedge clk);
        hold_sink = 1'b0;
      end
      for (int i = 0; i < 100; i++) send_triangle(random_triangle());
    join
  endtask

  task automatic test_random();
    idle_pct = 9;
    for (int i = 0; i < 1230; i++) begin
      if (i == 400) idle_pct = 0;
      if (i == 650) idle_pct = 9;
      send_triangle(random_triangle());
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n || hold_sink) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk) begin
    tb_tun_types::normal_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_normals.size() == 0) begin
        $error("unexpected result item");
        fails++;
      end else begin
        want = expected_normals.pop_front();
        if (out_ch.normal_x !== want.nx) begin
          $error("normal_x: expected %0d, got %0d", want.nx, out_ch.normal_x); fails++;
        end
        if (out_ch.normal_y !== want.ny) begin
          $error("normal_y: expected %0d, got %0d", want.ny, out_ch.normal_y); fails++;
        end
        if (out_ch.normal_z !== want.nz) begin
          $error("normal_z: expected %0d, got %0d", want.nz, out_ch.normal_z); fails++;
        end
        if (out_ch.degenerate !== want.degen) begin
          $error("degenerate: expected %0d, got %0d", want.degen, out_ch.degenerate);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    {in_ch.a_x, in_ch.a_y, in_ch.a_z, in_ch.b_x, in_ch.b_y, in_ch.b_z,
     in_ch.c_x, in_ch.c_y, in_ch.c_z} = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_thresholds();
    test_backpressure();
    test_random();
    drain_pipe();
    if (fails == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule

// ----- sim.f -----
src/tun_pkg.sv
src/tun_ifs.sv
src/tun_front.sv
src/tun_fifo.sv
src/tun_back.sv
src/triangle_unit_normal.sv
src/tun_checker.sv
test/tb_tun_ifs_note.sv
test/tb_triangle_unit_normal.sv
